// ----- src/heightmap_bilinear_sampler_top_macros.svh -----
// Assertion macros used by the sampler's top level.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked in and out of reset.
`define HBS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hbs_pkg.sv -----
// Shared types, constants and sizes of the heightmap bilinear sampler.
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_CHANNELS + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // Fixed field widths.
    localparam int ADDR_W  = 18;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 17;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 9;
    localparam int CFG_IW  = 2;
    localparam int HTW     = 10;
    localparam int HXW     = 26;
    localparam int OUT_W   = 26;

    localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_ZERO,
        KIND_SAMPLE
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_READ,
        S_DRAIN,
        S_LERPX,
        S_LERPY
    } t_back_state;

    // Saturated configuration as seen by front and back.
    typedef struct packed {
        logic [WW-1:0] width;
        logic [HW-1:0] height;
        logic [CW-1:0] chan;
    } t_cfg;

    // One classified request on its way to the back end.
    typedef struct packed {
        t_kind                kind;
        logic [ADDR_W-1:0]    load_address;
        logic [BYTE_W-1:0]    load_byte;
        logic [XW-1:0]        x0;
        logic [XW-1:0]        x1;
        logic [YW-1:0]        y0;
        logic [YW-1:0]        y1;
        logic [FRAC_W-1:0]    tx;
        logic [FRAC_W-1:0]    ty;
    } t_cmd;

    typedef struct packed {
        logic q_pop;
        logic out_load;
    } t_back_stat;

endpackage

// ----- src/hbs_front.sv -----
// Front end: classifies requests and turns coordinates into texel indices.
`timescale 1ns / 1ps

module hbs_front (
    input  hbs_pkg::t_cfg                      i_cfg,
    input  logic                               i_func,
    input  logic [hbs_pkg::ADDR_W-1:0]         i_load_address,
    input  logic [hbs_pkg::BYTE_W-1:0]         i_load_byte,
    input  logic [hbs_pkg::COORD_W-1:0]        i_u_coord,
    input  logic [hbs_pkg::COORD_W-1:0]        i_v_coord,
    output hbs_pkg::t_cmd                      o_cmd
);

    logic [hbs_pkg::COORD_W-1:0]            w_u;
    logic [hbs_pkg::COORD_W-1:0]            w_v;
    logic [hbs_pkg::WW-1:0]                 w_wm1;
    logic [hbs_pkg::HW-1:0]                 w_hm1;
    logic [hbs_pkg::COORD_W+hbs_pkg::WW-1:0] w_xs;
    logic [hbs_pkg::COORD_W+hbs_pkg::HW-1:0] w_ys;
    logic [hbs_pkg::XW-1:0]                 w_x0;
    logic [hbs_pkg::YW-1:0]                 w_y0;
    logic [hbs_pkg::WW-1:0]                 w_x0p1;
    logic [hbs_pkg::HW-1:0]                 w_y0p1;
    logic                                   w_zero;

    // Saturate coordinates above one.
    assign w_u = (i_u_coord > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : i_u_coord;
    assign w_v = (i_v_coord > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : i_v_coord;

    assign w_wm1 = i_cfg.width - 1'b1;
    assign w_hm1 = i_cfg.height - 1'b1;

    assign w_xs = w_u * w_wm1;
    assign w_ys = w_v * w_hm1;

    assign w_x0 = w_xs[hbs_pkg::FRAC_W +: hbs_pkg::XW];
    assign w_y0 = w_ys[hbs_pkg::FRAC_W +: hbs_pkg::YW];

    assign w_x0p1 = hbs_pkg::WW'(w_x0) + 1'b1;
    assign w_y0p1 = hbs_pkg::HW'(w_y0) + 1'b1;

    // No image, or a channel count without a height rule, gives zero.
    assign w_zero = (i_cfg.width == '0) || (i_cfg.height == '0) ||
                    (i_cfg.chan == '0) || (32'(i_cfg.chan) == 2);

    always_comb begin
        o_cmd.load_address = i_load_address;
        o_cmd.load_byte    = i_load_byte;
        o_cmd.x0           = w_x0;
        o_cmd.y0           = w_y0;
        o_cmd.x1           = (w_x0p1 < w_wm1) ? w_x0p1[hbs_pkg::XW-1:0]
                                              : w_wm1[hbs_pkg::XW-1:0];
        o_cmd.y1           = (w_y0p1 < w_hm1) ? w_y0p1[hbs_pkg::YW-1:0]
                                              : w_hm1[hbs_pkg::YW-1:0];
        o_cmd.tx           = w_xs[hbs_pkg::FRAC_W-1:0];
        o_cmd.ty           = w_ys[hbs_pkg::FRAC_W-1:0];
        if (i_func == hbs_pkg::FUNC_LOAD) begin
            o_cmd.kind = hbs_pkg::KIND_LOAD;
        end else if (w_zero) begin
            o_cmd.kind = hbs_pkg::KIND_ZERO;
        end else begin
            o_cmd.kind = hbs_pkg::KIND_SAMPLE;
        end
    end

endmodule

// ----- src/hbs_queue.sv -----
// Short request queue between front end and back end.
`timescale 1ns / 1ps

module hbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hbs_pkg::t_cmd  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output hbs_pkg::t_cmd  o_data,
    output logic           o_empty
);

    hbs_pkg::t_cmd            r_mem [hbs_pkg::QDEPTH];
    logic [hbs_pkg::QAW-1:0]  r_wr_ptr;
    logic [hbs_pkg::QAW-1:0]  r_rd_ptr;
    logic [hbs_pkg::QAW:0]    r_count;

    assign o_full  = (32'(r_count) == hbs_pkg::QDEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/hbs_back.sv -----
// Back end: image store, texel fetch sequencer, bilinear blend and result register.
`timescale 1ns / 1ps

module hbs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbs_pkg::t_cfg                 i_cfg,
    input  hbs_pkg::t_cmd                 i_q_data,
    input  logic                          i_q_empty,
    output hbs_pkg::t_back_stat           o_stat,
    output logic                          o_out_valid,
    output logic [hbs_pkg::OUT_W-1:0]     o_height_value,
    input  logic                          i_pop
);

    localparam logic [1:0] TEX_LAST = 2'd3;
    localparam logic [1:0] RGB_LAST = 2'd2;

    hbs_pkg::t_back_state r_state;
    hbs_pkg::t_back_state n_state;

    logic [hbs_pkg::BYTE_W-1:0] r_store [hbs_pkg::STORE_DEPTH];

    hbs_pkg::t_cmd              r_cmd;
    logic [hbs_pkg::PW-1:0]     r_row0;
    logic [hbs_pkg::PW-1:0]     r_row1;
    logic [1:0]                 r_tex;
    logic [1:0]                 r_byte;
    logic [hbs_pkg::BYTE_W-1:0] r_rd_data;
    logic [1:0]                 r_rd_tex;
    logic [1:0]                 r_rd_byte;
    logic                       r_rd_vld;
    logic [hbs_pkg::HTW-1:0]    r_h [4];
    logic [hbs_pkg::HXW-1:0]    r_hx0;
    logic [hbs_pkg::HXW-1:0]    r_hx1;
    logic                       r_out_vld;
    logic [hbs_pkg::OUT_W-1:0]  r_out_data;

    logic                                   w_rgb;
    logic [1:0]                             w_byte_last;
    logic                                   w_store_we;
    logic                                   w_q_pop;
    logic                                   w_out_load;
    logic [hbs_pkg::YW+hbs_pkg::WW-1:0]     w_row0_full;
    logic [hbs_pkg::YW+hbs_pkg::WW-1:0]     w_row1_full;
    logic [hbs_pkg::PW-1:0]                 w_pix;
    logic [hbs_pkg::PW+hbs_pkg::CW-1:0]     w_addr_full;
    logic [hbs_pkg::AW-1:0]                 w_rd_addr;
    logic [hbs_pkg::HTW-1:0]                w_d3;
    logic [hbs_pkg::COORD_W-1:0]            w_wx;
    logic [hbs_pkg::COORD_W-1:0]            w_tx;
    logic [hbs_pkg::COORD_W-1:0]            w_wy;
    logic [hbs_pkg::COORD_W-1:0]            w_ty;
    logic [hbs_pkg::HTW+hbs_pkg::COORD_W:0] w_hx0_sum;
    logic [hbs_pkg::HTW+hbs_pkg::COORD_W:0] w_hx1_sum;
    logic [hbs_pkg::HXW+hbs_pkg::COORD_W:0] w_hy_sum;

    assign w_rgb       = (32'(i_cfg.chan) >= 3);
    assign w_byte_last = w_rgb ? RGB_LAST : 2'd0;

    // Texel address: bit 0 of the texel number picks the column, bit 1 the row.
    assign w_row0_full = r_cmd.y0 * i_cfg.width;
    assign w_row1_full = r_cmd.y1 * i_cfg.width;
    assign w_pix = (r_tex[1] ? r_row1 : r_row0) +
                   hbs_pkg::PW'(r_tex[0] ? r_cmd.x1 : r_cmd.x0);
    assign w_addr_full = w_pix * i_cfg.chan + hbs_pkg::PW'(r_byte);
    assign w_rd_addr   = w_addr_full[hbs_pkg::AW-1:0];

    assign w_d3 = {2'b00, r_rd_data} + {1'b0, r_rd_data, 1'b0};

    assign w_tx = {1'b0, r_cmd.tx};
    assign w_wx = hbs_pkg::ONE_Q16 - w_tx;
    assign w_ty = {1'b0, r_cmd.ty};
    assign w_wy = hbs_pkg::ONE_Q16 - w_ty;

    assign w_hx0_sum = r_h[0] * w_wx + r_h[1] * w_tx;
    assign w_hx1_sum = r_h[2] * w_wx + r_h[3] * w_tx;
    assign w_hy_sum  = r_hx0 * w_wy + r_hx1 * w_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_q_pop    = 1'b0;
        w_store_we = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            hbs_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    w_q_pop = 1'b1;
                    unique case (i_q_data.kind)
                        hbs_pkg::KIND_LOAD: begin
                            w_store_we = (32'(i_q_data.load_address) <
                                          hbs_pkg::STORE_DEPTH);
                        end
                        hbs_pkg::KIND_ZERO: begin
                            n_state = hbs_pkg::S_LERPY;
                        end
                        hbs_pkg::KIND_SAMPLE: begin
                            n_state = hbs_pkg::S_ROW;
                        end
                        default: begin
                            n_state = hbs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hbs_pkg::S_ROW: begin
                n_state = hbs_pkg::S_READ;
            end
            hbs_pkg::S_READ: begin
                if (r_tex == TEX_LAST && r_byte == w_byte_last) begin
                    n_state = hbs_pkg::S_DRAIN;
                end
            end
            hbs_pkg::S_DRAIN: begin
                n_state = hbs_pkg::S_LERPX;
            end
            hbs_pkg::S_LERPX: begin
                n_state = hbs_pkg::S_LERPY;
            end
            hbs_pkg::S_LERPY: begin
                if (!r_out_vld || i_pop) begin
                    w_out_load = 1'b1;
                    n_state    = hbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hbs_pkg::S_IDLE;
            end
        endcase
    end

    // Image store: one write port for loads, one registered read port for fetches.
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[hbs_pkg::AW'(i_q_data.load_address)] <= i_q_data.load_byte;
        end
        r_rd_data <= r_store[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == hbs_pkg::S_READ);
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tex  <= r_tex;
        r_rd_byte <= r_byte;
        if (w_q_pop) begin
            r_cmd <= i_q_data;
            if (i_q_data.kind == hbs_pkg::KIND_ZERO) begin
                r_hx0 <= '0;
                r_hx1 <= '0;
            end
        end
        if (r_state == hbs_pkg::S_ROW) begin
            r_row0 <= w_row0_full[hbs_pkg::PW-1:0];
            r_row1 <= w_row1_full[hbs_pkg::PW-1:0];
            r_tex  <= '0;
            r_byte <= '0;
        end
        if (r_state == hbs_pkg::S_READ) begin
            if (r_byte == w_byte_last) begin
                r_byte <= '0;
                r_tex  <= r_tex + 1'b1;
            end else begin
                r_byte <= r_byte + 1'b1;
            end
        end
        // Accumulate texel heights: triple a single channel, sum three channels.
        if (r_rd_vld) begin
            if (r_rd_byte == '0) begin
                r_h[r_rd_tex] <= w_rgb ? hbs_pkg::HTW'(r_rd_data) : w_d3;
            end else begin
                r_h[r_rd_tex] <= r_h[r_rd_tex] + hbs_pkg::HTW'(r_rd_data);
            end
        end
        if (r_state == hbs_pkg::S_LERPX) begin
            r_hx0 <= w_hx0_sum[hbs_pkg::HXW-1:0];
            r_hx1 <= w_hx1_sum[hbs_pkg::HXW-1:0];
        end
        if (w_out_load) begin
            r_out_data <= w_hy_sum[hbs_pkg::FRAC_W +: hbs_pkg::OUT_W];
        end
    end

    assign o_stat.q_pop    = w_q_pop;
    assign o_stat.out_load = w_out_load;
    assign o_out_valid     = r_out_vld;
    assign o_height_value  = r_out_data;

endmodule

// ----- src/heightmap_bilinear_sampler_top.sv -----
// Top level of the heightmap bilinear sampler.
//
// Usage:
//   Configuration: write image_width (index 0), image_height (index 1) and
//   channel_count (index 2) through i_cfg_we/i_cfg_index/i_cfg_data while
//   the block is idle. Reset leaves width and height at 0 and one channel.
//   Requests enter on push/full: func 0 stores one byte of the interleaved
//   image, func 1 asks for a height sample at u,v (Q1.16). Only samples give
//   a result; it waits on o_height_value while empty is low and leaves on pop.
//   A four-entry request queue sits between the classifying front end and the
//   back end, so pushes keep flowing while the back end fetches or stalls.
//   Back-end work per request is set by the single byte-wide store read port:
//   a byte load is one store write; a sample makes 4 reads with one channel,
//   12 reads with three or more channels, and none for an empty image or an
//   unsupported channel count. The back end takes a request from the queue
//   only once it has finished the one before.
//   A stalled receiver holds the result register; the back end then waits in
//   its final blend step and the queue absorbs up to four further requests.
//   Reset empties the queue and result register; image bytes are undefined
//   until written.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_top_macros.svh"

module heightmap_bilinear_sampler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hbs_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [hbs_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_func,
    input  logic [hbs_pkg::ADDR_W-1:0]     i_load_address,
    input  logic [hbs_pkg::BYTE_W-1:0]     i_load_byte,
    input  logic [hbs_pkg::COORD_W-1:0]    i_u_coord,
    input  logic [hbs_pkg::COORD_W-1:0]    i_v_coord,
    output logic                           empty,
    input  logic                           pop,
    output logic [hbs_pkg::OUT_W-1:0]      o_height_value
);

    logic [hbs_pkg::CFG_W-1:0] r_image_width;
    logic [hbs_pkg::CFG_W-1:0] r_image_height;
    logic [2:0]                r_channel_count;

    hbs_pkg::t_cfg         w_cfg;
    hbs_pkg::t_cmd         w_front_cmd;
    hbs_pkg::t_cmd         w_q_data;
    hbs_pkg::t_back_stat   w_back_stat;
    logic                  w_q_push;
    logic                  w_q_empty;
    logic                  w_out_valid;

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= '0;
            r_image_height  <= '0;
            r_channel_count <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbs_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data;
                end
                hbs_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
                hbs_pkg::CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[2:0];
                end
                default: begin
                    r_image_width <= r_image_width;
                end
            endcase
        end
    end

    // Clamp oversized register values to the store's dimensions.
    always_comb begin
        w_cfg.width  = (32'(r_image_width) > hbs_pkg::MAX_WIDTH) ?
                       hbs_pkg::WW'(hbs_pkg::MAX_WIDTH) : hbs_pkg::WW'(r_image_width);
        w_cfg.height = (32'(r_image_height) > hbs_pkg::MAX_HEIGHT) ?
                       hbs_pkg::HW'(hbs_pkg::MAX_HEIGHT) : hbs_pkg::HW'(r_image_height);
        w_cfg.chan   = (32'(r_channel_count) > hbs_pkg::MAX_CHANNELS) ?
                       hbs_pkg::CW'(hbs_pkg::MAX_CHANNELS) : hbs_pkg::CW'(r_channel_count);
    end

    // Accept a request whenever the queue has room.
    assign w_q_push = push && !full;

    hbs_front u_front (
        .i_cfg          (w_cfg),
        .i_func         (i_func),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_u_coord      (i_u_coord),
        .i_v_coord      (i_v_coord),
        .o_cmd          (w_front_cmd)
    );

    hbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_back_stat.q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    hbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_data       (w_q_data),
        .i_q_empty      (w_q_empty),
        .o_stat         (w_back_stat),
        .o_out_valid    (w_out_valid),
        .o_height_value (o_height_value),
        .i_pop          (pop)
    );

    assign empty = !w_out_valid;

    // The back end takes from the queue only when a request waits there.
    `HBS_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, w_back_stat.q_pop, !w_q_empty, "request taken from empty queue")
    // A new result is loaded only when the result register is free or draining.
    `HBS_ASSERT_NOW(a_out_free, i_clk, i_rst_n, w_back_stat.out_load, empty || pop, "result register overwritten")
    // Reset leaves no result pending.
    `HBS_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, empty, "result pending after reset")

endmodule

// ----- tb/sv/heightmap_bilinear_sampler_checker.sv -----
// Checker for the heightmap sampler: predicts each height request and compares it.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hbs_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [hbs_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic                           i_func,
    input  logic [hbs_pkg::ADDR_W-1:0]     i_load_address,
    input  logic [hbs_pkg::BYTE_W-1:0]     i_load_byte,
    input  logic [hbs_pkg::COORD_W-1:0]    i_u_coord,
    input  logic [hbs_pkg::COORD_W-1:0]    i_v_coord,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [hbs_pkg::OUT_W-1:0]      i_height_value,
    output int                             o_pending,
    output int                             o_failures
);
    import hbs_pkg::*;

    // Shadow of the image bytes and of the three registers.
    logic [BYTE_W-1:0] image_bytes [STORE_DEPTH];
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [2:0]        chan_reg;

    logic [OUT_W-1:0]  expected_heights [$];
    int                failures = 0;

    function automatic longint unsigned texel_sum(longint unsigned px, longint unsigned py,
                                                  longint unsigned w, longint unsigned c);
        longint unsigned base;
        base = (py * w + px) * c;
        if (c == 1)
            return longint'(image_bytes[base]) * 3;
        if (c >= 3)
            return longint'(image_bytes[base]) + longint'(image_bytes[base + 1])
                 + longint'(image_bytes[base + 2]);
        return 0;
    endfunction

    function automatic longint unsigned lerp_q16(longint unsigned a, longint unsigned b,
                                                 longint unsigned t);
        return a * (65536 - t) + b * t;
    endfunction

    function automatic logic [OUT_W-1:0] predict_height(logic [COORD_W-1:0] u_in,
                                                        logic [COORD_W-1:0] v_in);
        longint unsigned w, h, c, u, v, xs, ys, x0, y0, x1, y1, tx, ty, hx0, hx1;
        w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        c = (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg;
        if (w == 0 || h == 0)
            return '0;
        u  = (u_in > ONE_Q16) ? ONE_Q16 : u_in;
        v  = (v_in > ONE_Q16) ? ONE_Q16 : v_in;
        xs = u * (w - 1);
        ys = v * (h - 1);
        x0 = xs >> FRAC_W;
        y0 = ys >> FRAC_W;
        tx = xs & 64'hFFFF;
        ty = ys & 64'hFFFF;
        // Clamp the far neighbour to the last column and row.
        x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
        hx0 = lerp_q16(texel_sum(x0, y0, w, c), texel_sum(x1, y0, w, c), tx);
        hx1 = lerp_q16(texel_sum(x0, y1, w, c), texel_sum(x1, y1, w, c), tx);
        return OUT_W'(lerp_q16(hx0, hx1, ty) >> FRAC_W);
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            width_reg  = '0;
            height_reg = '0;
            chan_reg   = 3'd1;
            expected_heights.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   width_reg  = i_cfg_data;
                    CFG_IMAGE_HEIGHT:  height_reg = i_cfg_data;
                    CFG_CHANNEL_COUNT: chan_reg   = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            // Retire before predicting: a request cannot finish in its own cycle.
            if (i_pop && !i_empty) begin
                if (expected_heights.size() == 0) begin
                    $error("height_value: expected nothing, actual %0d", i_height_value);
                    failures++;
                end else begin
                    want = expected_heights.pop_front();
                    if (want !== i_height_value) begin
                        $error("height_value: expected %0d, actual %0d", want, i_height_value);
                        failures++;
                    end
                end
            end
            if (i_push && !i_full) begin
                if (i_func == FUNC_SAMPLE)
                    expected_heights = {expected_heights,
                                        predict_height(i_u_coord, i_v_coord)};
                else
                    image_bytes[i_load_address] = i_load_byte;
            end
        end
        o_pending  <= expected_heights.size();
        o_failures <= failures;
    end

endmodule

// ----- tb/sv/heightmap_bilinear_sampler_top_tb.sv -----
// Top of the heightmap sampler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_top_tb;
    import hbs_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 40;    // covers a full sample plus a queue of loads
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any accepted transfer
    localparam int PHASE_ITEMS    = 98;
    localparam int NOISE_PCT      = 12;    // share of stray byte loads in random phases

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IW-1:0]    i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 push           = 1'b0;
    logic                 i_func         = FUNC_LOAD;
    logic [ADDR_W-1:0]    i_load_address = '0;
    logic [BYTE_W-1:0]    i_load_byte    = '0;
    logic [COORD_W-1:0]   i_u_coord      = '0;
    logic [COORD_W-1:0]   i_v_coord      = '0;
    logic                 pop            = 1'b0;
    logic                 full;
    logic                 empty;
    logic [OUT_W-1:0]     o_height_value;

    int pending;
    int failures;

    // Idle percentages, switched by the main sequence between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;

    // Saturated copy of the current registers, used to plan which bytes a sample reads.
    int unsigned cur_w = 0;
    int unsigned cur_h = 0;
    int unsigned cur_c = 1;
    bit          byte_written [STORE_DEPTH];

    int request_count = 0;
    int sample_count  = 0;
    int load_count    = 0;
    int setting_count = 0;

    heightmap_bilinear_sampler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_u_coord      (i_u_coord),
        .i_v_coord      (i_v_coord),
        .empty          (empty),
        .pop            (pop),
        .o_height_value (o_height_value)
    );

    heightmap_bilinear_sampler_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_full         (full),
        .i_func         (i_func),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_u_coord      (i_u_coord),
        .i_v_coord      (i_v_coord),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_height_value (o_height_value),
        .o_pending      (pending),
        .o_failures     (failures)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request and hold it until the block takes it. Random idle
    // cycles go in front; push is only lowered on idle cycles, so a request
    // that follows an accepted one keeps push high without a glitch.
    task automatic send_req(logic f, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                            logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= f;
        i_load_address <= addr;
        i_load_byte    <= data;
        i_u_coord      <= u;
        i_v_coord      <= v;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        request_count++;
        if (f == FUNC_LOAD) begin
            byte_written[addr] = 1'b1;
            load_count++;
        end else begin
            sample_count++;
        end
    endtask

    // Send a height request. First load any byte that the four texels would
    // read and that was never written, so the block never reads undefined
    // store contents. The unused load fields carry random values.
    task automatic send_sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned xi [2];
        int unsigned yi [2];
        int unsigned us, vs, base, nbytes;
        if (cur_w != 0 && cur_h != 0 && (cur_c == 1 || cur_c >= 3)) begin
            us    = (u > ONE_Q16) ? ONE_Q16 : u;
            vs    = (v > ONE_Q16) ? ONE_Q16 : v;
            xi[0] = (us * (cur_w - 1)) >> FRAC_W;
            yi[0] = (vs * (cur_h - 1)) >> FRAC_W;
            xi[1] = (xi[0] + 1 < cur_w - 1) ? xi[0] + 1 : cur_w - 1;
            yi[1] = (yi[0] + 1 < cur_h - 1) ? yi[0] + 1 : cur_h - 1;
            nbytes = (cur_c == 1) ? 1 : 3;
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 2; i++) begin
                    base = (yi[j] * cur_w + xi[i]) * cur_c;
                    for (int k = 0; k < nbytes; k++) begin
                        if (!byte_written[base + k])
                            send_req(FUNC_LOAD, ADDR_W'(base + k), BYTE_W'($urandom),
                                     COORD_W'($urandom), COORD_W'($urandom));
                    end
                end
            end
        end
        send_req(FUNC_SAMPLE, ADDR_W'($urandom), BYTE_W'($urandom), u, v);
    endtask

    // Pick a coordinate: mostly inside [0, 1.0], with the ends and
    // values above one (which the block saturates) mixed in.
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return ONE_Q16 - 1;
            3:       return COORD_W'($urandom_range(131071, 65537));
            default: return COORD_W'($urandom_range(65536));
        endcase
    endfunction

    // Drop push, wait until every expected height has come back, then let
    // trailing byte loads drain out of the request queue.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write all three registers back to back; call only with the block idle.
    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] c);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, c);
        i_cfg_we <= 1'b0;
        cur_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        cur_c = (c[2:0] > MAX_CHANNELS) ? MAX_CHANNELS : c[2:0];
        setting_count++;
    endtask

    // One random phase under a fixed image setting. Halfway through, pause
    // the sender until all heights are back; optionally start a long
    // receiver hold-off right away so the request queue fills and full rises.
    task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] c,
                             bit hold);
        int first;
        bit paused;
        drain_results();
        configure(w, h, c);
        if (hold)
            hold_req = 1'b1;
        first  = request_count;
        paused = 1'b0;
        while (request_count - first < PHASE_ITEMS) begin
            if (!paused && request_count - first >= PHASE_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(99) < NOISE_PCT)
                send_req(FUNC_LOAD, ADDR_W'($urandom), BYTE_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom));
            else
                send_sample(rand_coord(), rand_coord());
        end
    endtask

    // Receiver: pop at random, or hold pop low for a counted stretch when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles a third of the time, receiver most of the time.
        send_idle_pct = 33;
        recv_idle_pct = 86;

        // Reset leaves an empty image: heights must read zero, even above one.
        send_sample('0, '0);
        send_sample('1, '1);
        // Byte loads at both ends of the store and with alternating bits.
        send_req(FUNC_LOAD, '0, '0, '0, '0);
        send_req(FUNC_LOAD, '1, '1, '1, '1);
        send_req(FUNC_LOAD, 18'h15555, 8'hAA, 17'h15555, 17'h0AAAA);
        send_req(FUNC_LOAD, 18'h2AAAA, 8'h55, 17'h0AAAA, 17'h15555);

        // Small single-channel image: corners, center, just below one,
        // and coordinates above one that saturate.
        drain_results();
        configure(9'd3, 9'd3, 9'd1);
        send_sample('0, '0);
        send_sample(ONE_Q16, ONE_Q16);
        send_sample(ONE_Q16 - 1, ONE_Q16 - 1);
        send_sample(17'd32768, 17'd32768);
        send_sample('1, 17'd7);
        send_sample(17'd1, ONE_Q16 + 1);

        // Single pixel with three channels: both neighbours clamp onto it.
        drain_results();
        configure(9'd1, 9'd1, 9'd3);
        send_sample(17'd40000, 17'd20000);
        send_sample(ONE_Q16, '0);

        // Random phases; the first two keep the sender-light profile.
        run_phase(9'd256, 9'd256, 9'd4, 1'b0);
        run_phase(9'd37, 9'd23, 9'd1, 1'b1);

        // Swap the profiles: sender idles most, receiver a third.
        send_idle_pct = 86;
        recv_idle_pct = 33;
        run_phase(9'h1FF, 9'd2, 9'd5, 1'b0);   // oversized width and channel count
        run_phase(9'd2, 9'd256, 9'd2, 1'b0);   // two channels give zero height
        run_phase(9'd16, 9'd9, 9'd0, 1'b0);    // zero channels give zero height
        run_phase(9'd0, 9'd5, 9'd1, 1'b0);     // empty image, zero width

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(9'd7, 9'd0, 9'd3, 1'b0);     // empty image, zero height
        run_phase(9'd200, 9'd3, 9'h1FB, 1'b1); // upper data bits ignored: three channels
        run_phase(9'd300, 9'd300, 9'd7, 1'b0);
        run_phase(9'd5, 9'd4, 9'd1, 1'b0);
        run_phase(9'd257, 9'd1, 9'h1FC, 1'b0); // single row, four channels

        drain_results();

        $display("Covered %0d requests (%0d height samples, %0d byte loads) over %0d settings,",
                 request_count, sample_count, load_count, setting_count);
        $display("with both idle profiles, no idling, and two long receiver hold-offs.");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/hbs_pkg.sv
src/hbs_front.sv
src/hbs_queue.sv
src/hbs_back.sv
src/heightmap_bilinear_sampler_top.sv
tb/sv/heightmap_bilinear_sampler_checker.sv
tb/sv/heightmap_bilinear_sampler_top_tb.sv
